[rtl/core/pfs_pkg.sv]
`default_nettype none

package pfs_pkg;

	// default store depth in characters
	localparam int MAX_LEN_DEF = 1024;

	localparam int BYTE_W   = 8;
	localparam int PREFIX_W = 10;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// classification made by the front for each word
	typedef struct packed {
		logic first;  // first character of a string
		logic ovf;    // position beyond the store depth
	} pfs_kind_t;

	// back sequencer states
	typedef enum logic {
		PFS_IDLE,
		PFS_CHECK
	} pfs_state_t;

endpackage

`default_nettype wire

[rtl/core/pfs_front.sv]
`default_nettype none

module pfs_front #(
	parameter int MAX_LEN = pfs_pkg::MAX_LEN_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire  [pfs_pkg::BYTE_W-1:0] byte_in,
	input  wire                      start_new,
	output logic                     push_valid,
	input  wire                      push_ready,
	output logic [pfs_pkg::BYTE_W-1:0] push_byte,
	output logic [$clog2(MAX_LEN)-1:0] push_idx,
	output pfs_pkg::pfs_kind_t       push_kind
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int PW = $clog2(MAX_LEN + 1);

	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_base;
	logic [PW-1:0] pos_d;
	logic          full;
	logic          accept;

	// pass the handshake straight to the queue
	assign push_valid = in_valid;
	assign in_ready   = push_ready;
	assign accept     = in_valid && push_ready;

	// restart the string on the start flag, classify the position
	always_comb begin
		pos_base = start_new ? '0 : pos_q;
		full     = (pos_base == PW'(MAX_LEN));
		pos_d    = full ? pos_base : pos_base + PW'(1);
	end

	assign push_byte       = byte_in;
	assign push_idx        = pos_base[AW-1:0];
	assign push_kind.first = (pos_base == '0);
	assign push_kind.ovf   = full;

	// advance the position, saturate at the store depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/pfs_queue.sv]
`default_nettype none

module pfs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pfs_pkg::QUEUE_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  wire  [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  wire              pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// store the incoming word
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and track the fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/pfs_back.sv]
`default_nettype none

module pfs_back #(
	parameter int MAX_LEN = pfs_pkg::MAX_LEN_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        q_valid,
	output logic                       q_ready,
	input  wire  [pfs_pkg::BYTE_W-1:0] q_byte,
	input  wire  [$clog2(MAX_LEN)-1:0] q_idx,
	input  pfs_pkg::pfs_kind_t         q_kind,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [pfs_pkg::PREFIX_W-1:0] prefix_len,
	output logic                       overflow
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int RW = (AW > pfs_pkg::PREFIX_W) ? AW : pfs_pkg::PREFIX_W;

	// character and prefix stores
	logic [pfs_pkg::BYTE_W-1:0] char_mem [MAX_LEN];
	logic [AW-1:0]              pref_mem [MAX_LEN];

	pfs_pkg::pfs_state_t state_q, state_d;

	logic [pfs_pkg::BYTE_W-1:0] byte_q;
	logic [AW-1:0]              idx_q;
	logic [AW-1:0]              cand_q, cand_d;
	logic [AW-1:0]              last_res_q, last_res_d;
	logic [pfs_pkg::BYTE_W-1:0] char_rd_q;
	logic [AW-1:0]              pref_rd_q;
	logic [AW-1:0]              char_addr;
	logic [AW-1:0]              pref_addr;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [pfs_pkg::BYTE_W-1:0] wr_char;
	logic [AW-1:0]              wr_pref;
	logic                       capture;
	logic                       load_out;
	logic [AW-1:0]              res;
	logic                       ovf_res;
	logic                       out_free;
	logic                       match;
	logic                       out_valid_q;
	logic [pfs_pkg::PREFIX_W-1:0] prefix_len_q;
	logic                       overflow_q;
	logic [RW-1:0]              res_ext;

	assign out_free = !out_valid_q || out_ready;
	assign match    = (char_rd_q == byte_q);

	// sequence the failure-chain walk
	always_comb begin
		state_d    = state_q;
		cand_d     = cand_q;
		last_res_d = last_res_q;
		q_ready    = 1'b0;
		capture    = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = idx_q;
		wr_char    = byte_q;
		wr_pref    = '0;
		load_out   = 1'b0;
		res        = '0;
		ovf_res    = 1'b0;
		char_addr  = cand_q;
		pref_addr  = cand_q - AW'(1);
		unique case (state_q)
			pfs_pkg::PFS_IDLE: begin
				if (q_valid) begin
					priority if (q_kind.ovf) begin
						if (out_free) begin
							q_ready  = 1'b1;
							load_out = 1'b1;
							ovf_res  = 1'b1;
						end
					end else if (q_kind.first) begin
						if (out_free) begin
							q_ready    = 1'b1;
							load_out   = 1'b1;
							wr_en      = 1'b1;
							wr_addr    = q_idx;
							wr_char    = q_byte;
							last_res_d = '0;
						end
					end else begin
						// previous word's result is the first candidate
						q_ready   = 1'b1;
						capture   = 1'b1;
						cand_d    = last_res_q;
						char_addr = last_res_q;
						pref_addr = last_res_q - AW'(1);
						state_d   = pfs_pkg::PFS_CHECK;
					end
				end
			end
			pfs_pkg::PFS_CHECK: begin
				if (match || cand_q == '0) begin
					res = match ? cand_q + AW'(1) : '0;
					if (out_free) begin
						load_out   = 1'b1;
						wr_en      = 1'b1;
						wr_pref    = res;
						last_res_d = res;
						state_d    = pfs_pkg::PFS_IDLE;
					end
				end else begin
					// drop to the next link of the chain
					cand_d    = pref_rd_q;
					char_addr = pref_rd_q;
					pref_addr = pref_rd_q - AW'(1);
				end
			end
			default: begin
				state_d = pfs_pkg::PFS_IDLE;
			end
		endcase
	end

	// store access, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			char_mem[wr_addr] <= wr_char;
		end
		char_rd_q <= char_mem[char_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pref_mem[wr_addr] <= wr_pref;
		end
		pref_rd_q <= pref_mem[pref_addr];
	end

	// hold the word under work
	always_ff @(posedge clk) begin
		if (capture) begin
			byte_q <= q_byte;
			idx_q  <= q_idx;
		end
		cand_q <= cand_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pfs_pkg::PFS_IDLE;
			last_res_q <= '0;
		end else begin
			state_q    <= state_d;
			last_res_q <= last_res_d;
		end
	end

	// output register
	assign res_ext = RW'(res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			prefix_len_q <= res_ext[pfs_pkg::PREFIX_W-1:0];
			overflow_q   <= ovf_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign prefix_len = prefix_len_q;
	assign overflow   = overflow_q;

endmodule

`default_nettype wire

[rtl/core/prefix_function_stream.sv]
// Streaming prefix (failure) function of a byte string.
// Input channel: in_valid/in_ready with byte_in and start_new. start_new marks
// the first character of a string; the first word after reset also starts one.
// Output channel: out_valid/out_ready with prefix_len and overflow, exactly one
// word per input word, in order. Bytes beyond MAX_LEN characters of a string
// give overflow = 1 and prefix_len = 0 until the next start_new.
// A front stage tracks the position, a two-entry queue decouples it from the
// back stage, which walks the failure chain through the character and prefix
// stores (one read port each, registered read data).
// Path: a first or overflow word goes from the queue into the output register
// directly; any other word is captured, then PFS_CHECK examines chain links.
// The back stage takes a new word from the queue only in PFS_IDLE, so a word
// under a chain walk holds later words in the queue until its result loads.
// The chain walk examines one link per cycle, bounded by the store read ports.
// Reset clears the position, the queue and the output valid; stores are not
// cleared. When out_ready is low the output word holds, the back stage stalls
// on its finished word, and the queue fills before in_ready drops.
`default_nettype none

module prefix_function_stream #(
	parameter int MAX_LEN = pfs_pkg::MAX_LEN_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [pfs_pkg::BYTE_W-1:0]   byte_in,
	input  wire                          start_new,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [pfs_pkg::PREFIX_W-1:0] prefix_len,
	output logic                         overflow
);

	localparam int AW     = $clog2(MAX_LEN);
	localparam int KIND_W = $bits(pfs_pkg::pfs_kind_t);
	localparam int Q_W    = pfs_pkg::BYTE_W + AW + KIND_W;

	logic                       push_valid;
	logic                       push_ready;
	logic [pfs_pkg::BYTE_W-1:0] push_byte;
	logic [AW-1:0]              push_idx;
	pfs_pkg::pfs_kind_t         push_kind;
	logic [Q_W-1:0]             push_data;
	logic                       q_valid;
	logic                       q_ready;
	logic [Q_W-1:0]             q_data;
	logic [pfs_pkg::BYTE_W-1:0] q_byte;
	logic [AW-1:0]              q_idx;
	pfs_pkg::pfs_kind_t         q_kind;

	pfs_front #(
		.MAX_LEN(MAX_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.byte_in   (byte_in),
		.start_new (start_new),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_byte (push_byte),
		.push_idx  (push_idx),
		.push_kind (push_kind)
	);

	// pack the word for the queue
	assign push_data = {push_byte, push_idx, push_kind};

	pfs_queue #(
		.WIDTH(Q_W),
		.DEPTH(pfs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_data)
	);

	// unpack at the back side
	assign q_byte = q_data[Q_W-1 -: pfs_pkg::BYTE_W];
	assign q_idx  = q_data[KIND_W +: AW];
	assign q_kind = pfs_pkg::pfs_kind_t'(q_data[KIND_W-1:0]);

	pfs_back #(
		.MAX_LEN(MAX_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_byte    (q_byte),
		.q_idx     (q_idx),
		.q_kind    (q_kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.prefix_len(prefix_len),
		.overflow  (overflow)
	);

endmodule

`default_nettype wire

[verif/testbench.sv]
module testbench;

	localparam int DEPTH        = pfs_pkg::MAX_LEN_DEF;
	localparam int N_RANDOM     = 1300;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 64;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int N_PLAN       = 24;

	// one result word as the block should deliver it
	typedef struct packed {
		logic [pfs_pkg::PREFIX_W-1:0] len;
		logic                         ovf;
	} border_t;

	// directed row: input word plus, where obvious, the result typed in
	typedef struct packed {
		logic [pfs_pkg::BYTE_W-1:0]   ch;
		logic                         first;
		logic                         typed;
		logic [pfs_pkg::PREFIX_W-1:0] len;
		logic                         ovf;
	} plan_row_t;

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	logic [pfs_pkg::BYTE_W-1:0]   byte_in   = '0;
	logic                         start_new = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [pfs_pkg::PREFIX_W-1:0] prefix_len;
	logic                         overflow;

	// predictor state: string so far and its border lengths
	logic [pfs_pkg::BYTE_W-1:0] str_chars [DEPTH];
	int                         str_borders [DEPTH];
	int                         str_pos = 0;

	border_t border_due [$];
	int      errors   = 0;
	int      cycles   = 0;
	int      gap_pct  = 0;
	bit      quiet    = 1'b0;
	bit      hold_req = 1'b0;

	// first character after reset, start flag with zeros, classic ababacababa
	plan_row_t plan [N_PLAN] = '{
		'{8'hFF, 1'b0, 1'b1, 10'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h00, 1'b1, 1'b1, 10'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h61, 1'b1, 1'b1, 10'd0, 1'b0},
		'{8'h62, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h61, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h62, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h61, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h63, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h61, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h62, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h61, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h62, 1'b0, 1'b0, 10'd0, 1'b0},
		'{8'h61, 1'b0, 1'b0, 10'd0, 1'b0}
	};

	prefix_function_stream #(
		.MAX_LEN(DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.byte_in   (byte_in),
		.start_new (start_new),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.prefix_len(prefix_len),
		.overflow  (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// append one character and return the longest border ending there
	function automatic border_t border_step(input logic [pfs_pkg::BYTE_W-1:0] c,
			input logic first);
		border_t res;
		int      k;
		int      r;
		res = '0;
		if (first)
			str_pos = 0;
		if (str_pos >= DEPTH) begin
			// store full: nothing stored, position saturates
			str_pos = DEPTH;
			res.ovf = 1'b1;
			return res;
		end
		r = 0;
		if (str_pos > 0) begin
			// walk the failure chain until the next character matches
			k = str_borders[str_pos - 1];
			while (k > 0 && str_chars[k] != c)
				k = str_borders[k - 1];
			if (str_chars[k] == c)
				r = k + 1;
		end
		str_chars[str_pos]   = c;
		str_borders[str_pos] = r;
		str_pos++;
		res.len = r[pfs_pkg::PREFIX_W-1:0];
		return res;
	endfunction

	// offer one word, hold it until taken, then log what it should produce
	task automatic send_word(input logic [pfs_pkg::BYTE_W-1:0] c, input logic first,
			input logic typed, input border_t typed_res);
		border_t pred;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		byte_in   <= c;
		start_new <= first;
		do @(posedge clk); while (!in_ready);
		pred = border_step(c, first);
		border_due.push_back(typed ? typed_res : pred);
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin : sink
		int stall_pct;
		int n;
		stall_pct = 0;
		n = 0;
		forever begin
			@(posedge clk);
			n++;
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 40;
				endcase
			end
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// compare each delivered word with the oldest pending one
	always @(posedge clk) begin
		border_t want;
		if (arst_n && out_valid && out_ready) begin
			if (border_due.size() == 0) begin
				$display("%0t: unexpected word prefix_len=%0d overflow=%0d",
					$time, prefix_len, overflow);
				errors++;
			end else begin
				want = border_due.pop_front();
				if (prefix_len !== want.len) begin
					$display("%0t: prefix_len mismatch expected %0d actual %0d",
						$time, want.len, prefix_len);
					errors++;
				end
				if (overflow !== want.ovf) begin
					$display("%0t: overflow mismatch expected %0d actual %0d",
						$time, want.ovf, overflow);
					errors++;
				end
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic [pfs_pkg::BYTE_W-1:0] sym [3];
		logic [pfs_pkg::BYTE_W-1:0] pat [6];
		logic [pfs_pkg::BYTE_W-1:0] c;
		logic                       first;
		int                         sent;
		int                         strings;
		int                         len;
		int                         mode;
		int                         period;
		bit                         long_done;
		sent = 0;
		strings = 0;
		long_done = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		for (int i = 0; i < N_PLAN; i++)
			send_word(plan[i].ch, plan[i].first, plan[i].typed, {plan[i].len, plan[i].ovf});

		// random strings
		while (sent < N_RANDOM) begin
			case ($urandom_range(0, 3))
				0, 1: gap_pct = 0;
				2: gap_pct = 15;
				default: gap_pct = 50;
			endcase
			if (strings == 3)
				hold_req = 1'b1;
			strings++;

			if (!long_done && sent >= 50) begin
				// one run of a single character filling the store depth, then random bytes past it
				long_done = 1'b1;
				c = 8'($urandom_range(0, 255));
				len = DEPTH + $urandom_range(1, 20);
				for (int i = 0; i < len; i++) begin
					send_word(i < DEPTH ? c : 8'($urandom_range(0, 255)), i == 0,
						1'b0, '0);
					sent++;
					if (sent >= N_RANDOM - 150)
						quiet = 1'b1;
				end
				continue;
			end

			for (int j = 0; j < 3; j++)
				sym[j] = 8'($urandom_range(0, 255));
			period = $urandom_range(1, 6);
			for (int j = 0; j < 6; j++)
				pat[j] = sym[$urandom_range(0, 1)];
			mode = $urandom_range(0, 3);
			len = $urandom_range(0, 7) == 0 ? 1 : $urandom_range(2, 40);
			// now and then continue the previous string instead of starting anew
			first = $urandom_range(0, 9) != 0;
			for (int i = 0; i < len; i++) begin
				case (mode)
					0: c = 8'($urandom_range(0, 255));
					1: c = sym[$urandom_range(0, 1)];
					2: c = ($urandom_range(0, 7) == 0) ? sym[$urandom_range(0, 2)]
						: pat[i % period];
					default: c = sym[$urandom_range(0, 2)];
				endcase
				send_word(c, i == 0 ? first : 1'b0, 1'b0, '0);
				sent++;
				if (sent >= N_RANDOM - 150)
					quiet = 1'b1;
			end
		end
		in_valid <= 1'b0;

		// drain
		while (border_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[prefix_function_stream.f]
rtl/core/pfs_pkg.sv
rtl/core/pfs_front.sv
rtl/core/pfs_queue.sv
rtl/core/pfs_back.sv
rtl/core/prefix_function_stream.sv
verif/testbench.sv
